// ===== sv/vconv_pkg.sv =====
// Shared types and constants for the valid-region 2D convolution block.
// No dependencies; imported by every module of the block.
`default_nettype none

package vconv_pkg;

    localparam int MAX_HEIGHT = 2048;
    localparam int ACC_W      = 48;
    localparam int COORD_W    = 11;
    localparam int COEF_W     = 16;
    localparam int KIDX_W     = 4;
    localparam int CFG_W      = 12;
    localparam int DOUT_W     = 72;

    // Item kinds carried in s_tuser
    localparam logic ACT_COEF  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_KERNEL_HEIGHT,
        REG_KERNEL_WIDTH
    } cfg_reg_t;

    // Effective (clamped) frame and kernel sizes
    typedef struct packed {
        logic [CFG_W-1:0]  img_w;
        logic [CFG_W-1:0]  img_h;
        logic [KIDX_W-1:0] ker_h;
        logic [KIDX_W-1:0] ker_w;
    } vconv_size_t;

    // Classified request handed from the front end to the datapath
    typedef struct packed {
        logic                     pixel_item;
        logic [KIDX_W-1:0]        coef_row;
        logic [KIDX_W-1:0]        coef_col;
        logic signed [COEF_W-1:0] coef_value;
        logic                     emit;
        logic                     last;
        logic [COORD_W-1:0]       out_row;
        logic [COORD_W-1:0]       out_col;
    } vconv_item_t;

endpackage

`default_nettype wire

// ===== sv/vconv_front.sv =====
// Front end: raster counters and request classification.
// Depends on vconv_pkg.
`default_nettype none

module vconv_front
    import vconv_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16,
    localparam int CW        = $clog2(MAX_WIDTH)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire vconv_size_t              size,
    input  wire logic                     push,
    input  wire logic                     action,
    input  wire logic [KIDX_W-1:0]        coef_row,
    input  wire logic [KIDX_W-1:0]        coef_col,
    input  wire logic signed [COEF_W-1:0] coef_value,
    input  wire logic [PIXEL_BITS-1:0]    pixel,
    output vconv_item_t                   item,
    output logic [PIXEL_BITS-1:0]         item_pixel,
    output logic [CW-1:0]                 item_addr
);

    logic [COORD_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]      col_count_reg, col_count_next;
    logic [CW-1:0]      c_eff;
    logic [31:0]        r_ext, c_ext;
    logic               col_end, row_end;

    always_comb
    begin
        c_eff   = (32'(col_count_reg) >= MAX_WIDTH) ? '0 : col_count_reg;
        c_ext   = 32'(c_eff);
        r_ext   = 32'(row_count_reg);
        col_end = (c_ext + 32'd1) >= 32'(size.img_w);
        row_end = (r_ext + 32'd1) >= 32'(size.img_h);

        if (col_end)
        begin
            col_count_next = '0;
            row_count_next = row_end ? '0 : COORD_W'(r_ext + 32'd1);
        end
        else
        begin
            col_count_next = CW'(c_ext + 32'd1);
            row_count_next = row_count_reg;
        end

        item.pixel_item = (action == ACT_PIXEL);
        item.coef_row   = coef_row;
        item.coef_col   = coef_col;
        item.coef_value = coef_value;
        item.emit       = ((r_ext + 32'd1) >= 32'(size.ker_h)) &&
                          ((c_ext + 32'd1) >= 32'(size.ker_w));
        item.last       = row_end && col_end;
        item.out_row    = COORD_W'(r_ext - 32'(size.ker_h) + 32'd1);
        item.out_col    = COORD_W'(c_ext - 32'(size.ker_w) + 32'd1);
        item_pixel      = pixel;
        item_addr       = c_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (push && action == ACT_PIXEL)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vconv_queue.sv =====
// Short request queue between front end and datapath.
// Depends on vconv_pkg (house import only).
`default_nettype none

module vconv_queue
    import vconv_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW   = $clog2(DEPTH + 1)
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output logic [W-1:0]      head_data
);

    logic [W-1:0]  slot_reg [0:DEPTH-1];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [NW-1:0] count_reg;

    assign full       = (32'(count_reg) == DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (32'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/vconv_back.sv =====
// Datapath: line memories, window, coefficient cells, product array,
// registered adder tree and output register. Depends on vconv_pkg.
`default_nettype none

module vconv_back
    import vconv_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_KERNEL = 15,
    parameter int PIXEL_BITS = 16,
    localparam int CW        = $clog2(MAX_WIDTH)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vconv_size_t           size,
    input  wire logic                  head_valid,
    input  wire vconv_item_t           head_item,
    input  wire logic [PIXEL_BITS-1:0] head_pixel,
    input  wire logic [CW-1:0]         head_addr,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DOUT_W-1:0]          m_tdata,
    output logic                       m_tlast
);

    localparam int MK  = MAX_KERNEL;
    localparam int LR  = MK - 1;
    localparam int LRD = (LR > 0) ? LR : 1;
    localparam int N   = MK * MK;
    localparam int L   = $clog2(N);
    localparam int P   = 1 << L;
    localparam int PW  = PIXEL_BITS + COEF_W + 1;

    typedef struct packed {
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } tag_t;

    logic adv;

    logic                  s1_valid_reg, s1_fwd_reg;
    vconv_item_t           s1_item_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [CW-1:0]         s1_addr_reg;
    logic                  s1_pix;

    logic [PIXEL_BITS-1:0] rd_reg      [0:LRD-1];
    logic [PIXEL_BITS-1:0] cv_hold_reg [0:LRD-1];
    logic [PIXEL_BITS-1:0] cv          [0:MK-1];
    logic [PIXEL_BITS-1:0] win_in      [0:MK-1];
    logic [PIXEL_BITS-1:0] win_reg     [0:MK-1][0:MK-1];

    logic        s2_valid_reg;
    vconv_item_t s2_item_reg;

    logic signed [COEF_W-1:0]     coef_reg [0:MK-1][0:MK-1];
    logic [PIXEL_BITS-1:0]        tap      [0:MK-1][0:MK-1];
    logic signed [PW-1:0]         prod     [0:N-1];
    logic signed [ACC_W-1:0]      node_reg [1:2*P-1];
    tag_t                         tag_reg  [0:L];
    logic                         tag_valid_reg [0:L];

    logic                     m_tvalid_reg;
    logic                     m_tlast_reg;
    logic [DOUT_W-1:0]        m_tdata_reg;

    // Whole datapath moves together; the output register parts the sides
    assign adv    = !m_tvalid_reg || m_tready;
    assign pop    = adv && head_valid;
    assign s1_pix = s1_valid_reg && s1_item_reg.pixel_item;

    // Stage 1: read line memories, then write back the shifted column
    for (genvar k = 0; k < LR; k++)
    begin : g_line
        logic [PIXEL_BITS-1:0] line_mem [0:MAX_WIDTH-1];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (s1_pix)
                begin
                    line_mem[s1_addr_reg] <= cv[k];
                end
                rd_reg[k] <= line_mem[head_addr];
            end
        end
    end

    if (LR == 0)
    begin : g_no_line
        always_ff @(posedge clk)
        begin
            rd_reg[0] <= head_pixel;
        end
    end

    // Column vector; forward the previous column when it hit the same address
    always_comb
    begin
        cv[0] = s1_pixel_reg;
        for (int k = 1; k < MK; k++)
        begin
            cv[k] = s1_fwd_reg ? cv_hold_reg[k-1] : rd_reg[k-1];
        end
    end

    // Window rows are stored in kernel order: row fh holds source row r-(kh-1)+fh
    always_comb
    begin
        for (int fh = 0; fh < MK; fh++)
        begin
            win_in[fh] = '0;
            for (int k = 0; k < MK; k++)
            begin
                if (fh < int'(size.ker_h) && k == int'(size.ker_h) - 1 - fh)
                begin
                    win_in[fh] = cv[k];
                end
            end
        end
    end

    // Taps aligned to kernel columns, masked outside the active kernel
    always_comb
    begin
        for (int fh = 0; fh < MK; fh++)
        begin
            for (int fw = 0; fw < MK; fw++)
            begin
                tap[fh][fw] = '0;
                for (int j = 0; j < MK; j++)
                begin
                    if (fh < int'(size.ker_h) && fw < int'(size.ker_w) &&
                        j == int'(size.ker_w) - 1 - fw)
                    begin
                        tap[fh][fw] = win_reg[fh][j];
                    end
                end
                prod[fh*MK + fw] = $signed({1'b0, tap[fh][fw]}) * coef_reg[fh][fw];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg  <= head_item;
            s1_pixel_reg <= head_pixel;
            s1_addr_reg  <= head_addr;
            s1_fwd_reg   <= s1_pix && (s1_addr_reg == head_addr);
            s2_item_reg  <= s1_item_reg;

            if (s1_pix)
            begin
                for (int k = 0; k < LRD; k++)
                begin
                    cv_hold_reg[k] <= cv[k];
                end
                for (int fh = 0; fh < MK; fh++)
                begin
                    for (int j = MK - 1; j > 0; j--)
                    begin
                        win_reg[fh][j] <= win_reg[fh][j-1];
                    end
                    win_reg[fh][0] <= win_in[fh];
                end
            end

            // Coefficient write lands in the multiply stage to keep request order
            if (s2_valid_reg && !s2_item_reg.pixel_item)
            begin
                for (int i = 0; i < MK; i++)
                begin
                    for (int j = 0; j < MK; j++)
                    begin
                        if (32'(s2_item_reg.coef_row) == i && 32'(s2_item_reg.coef_col) == j)
                        begin
                            coef_reg[i][j] <= s2_item_reg.coef_value;
                        end
                    end
                end
            end

            for (int i = 0; i < N; i++)
            begin
                node_reg[P+i] <= ACC_W'(prod[i]);
            end
            for (int i = N; i < P; i++)
            begin
                node_reg[P+i] <= '0;
            end
            for (int i = 1; i < P; i++)
            begin
                node_reg[i] <= node_reg[2*i] + node_reg[2*i+1];
            end

            tag_reg[0].last <= s2_item_reg.last;
            tag_reg[0].row  <= s2_item_reg.out_row;
            tag_reg[0].col  <= s2_item_reg.out_col;
            for (int l = 1; l <= L; l++)
            begin
                tag_reg[l].last <= tag_reg[l-1].last;
                tag_reg[l].row  <= tag_reg[l-1].row;
                tag_reg[l].col  <= tag_reg[l-1].col;
            end

            if (tag_valid_reg[L])
            begin
                m_tdata_reg <= DOUT_W'({tag_reg[L].col, tag_reg[L].row, node_reg[1]});
                m_tlast_reg <= tag_reg[L].last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int l = 0; l <= L; l++)
            begin
                tag_valid_reg[l] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg     <= head_valid;
            s2_valid_reg     <= s1_valid_reg;
            tag_valid_reg[0] <= s2_valid_reg && s2_item_reg.pixel_item && s2_item_reg.emit;
            for (int l = 1; l <= L; l++)
            begin
                tag_valid_reg[l] <= tag_valid_reg[l-1];
            end
            m_tvalid_reg <= tag_valid_reg[L];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== sv/valid_2d_convolution.sv =====
// Top level of the valid-region 2D convolution: configuration registers,
// front end, request queue and datapath. Depends on vconv_pkg and submodules.
//
// Takes one request per clock (coefficient write or raster pixel) while the
// queue has room and returns one result per clock while the receiver is ready,
// once a full kernel window lies inside the frame. A result passes through the
// line-memory read, the window shift, the product array, each adder-tree level
// and the output register in that order. The line memories take one read and
// one write per clock, which sets the rate. Kernel coefficients never loaded
// give undefined results.
`default_nettype none

module valid_2d_convolution
    import vconv_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_KERNEL = 15,
    parameter int PIXEL_BITS = 16,
    localparam int DIN_W     = ((24 + PIXEL_BITS + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // coef_row, coef_col, coef_value, pixel
    input  wire logic [DIN_W-1:0]  s_tdata,
    // action
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // result_value, out_row, out_col
    output logic [DOUT_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int IW = $bits(vconv_item_t);
    localparam int QW = IW + PIXEL_BITS + CW;

    logic [CFG_W-1:0]  img_w_reg, img_h_reg;
    logic [KIDX_W-1:0] ker_h_reg, ker_w_reg;
    vconv_size_t       size;

    logic                  push, full, pop, head_valid;
    vconv_item_t           f_item, head_item;
    logic [PIXEL_BITS-1:0] f_pixel, head_pixel;
    logic [CW-1:0]         f_addr, head_addr;
    logic [QW-1:0]         head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= CFG_W'(2048);
            img_h_reg <= CFG_W'(2048);
            ker_h_reg <= KIDX_W'(15);
            ker_w_reg <= KIDX_W'(15);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:   img_w_reg <= cfg_wdata;
                REG_IMAGE_HEIGHT:  img_h_reg <= cfg_wdata;
                REG_KERNEL_HEIGHT: ker_h_reg <= cfg_wdata[KIDX_W-1:0];
                REG_KERNEL_WIDTH:  ker_w_reg <= cfg_wdata[KIDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one; clamp to the supported maxima
    always_comb
    begin
        size.img_w = (img_w_reg == '0) ? CFG_W'(1) :
                     ((32'(img_w_reg) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : img_w_reg);
        size.img_h = (img_h_reg == '0) ? CFG_W'(1) :
                     ((32'(img_h_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : img_h_reg);
        size.ker_h = (ker_h_reg == '0) ? KIDX_W'(1) :
                     ((32'(ker_h_reg) > MAX_KERNEL) ? KIDX_W'(MAX_KERNEL) : ker_h_reg);
        size.ker_w = (ker_w_reg == '0) ? KIDX_W'(1) :
                     ((32'(ker_w_reg) > MAX_KERNEL) ? KIDX_W'(MAX_KERNEL) : ker_w_reg);
    end

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    vconv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .size       (size),
        .push       (push),
        .action     (s_tuser),
        .coef_row   (s_tdata[3:0]),
        .coef_col   (s_tdata[7:4]),
        .coef_value ($signed(s_tdata[23:8])),
        .pixel      (s_tdata[24 +: PIXEL_BITS]),
        .item       (f_item),
        .item_pixel (f_pixel),
        .item_addr  (f_addr)
    );

    vconv_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({f_addr, f_pixel, f_item}),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_item  = vconv_item_t'(head_data[IW-1:0]);
    assign head_pixel = head_data[IW +: PIXEL_BITS];
    assign head_addr  = head_data[IW + PIXEL_BITS +: CW];

    vconv_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .size       (size),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pixel (head_pixel),
        .head_addr  (head_addr),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sv/vconv_checker.sv =====
// Port-level checker for valid_2d_convolution, bound to the top level.
// Depends on vconv_pkg.
`default_nettype none

module vconv_checker
    import vconv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic              s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [DOUT_W-1:0] m_tdata,
    input  wire logic              m_tlast
);

    logic [15:0] pending_reg;
    logic        pix_in, res_out;

    assign pix_in  = s_tvalid && s_tready && (s_tuser == ACT_PIXEL);
    assign res_out = m_tvalid && m_tready;

    // Upper bound on pixels taken whose result may still come out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (pix_in && !res_out)
        begin
            pending_reg <= (pending_reg == '1) ? pending_reg : pending_reg + 1'b1;
        end
        else if (res_out && !pix_in && pending_reg != '0)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_out |-> (pending_reg != '0) || pix_in)
        else $error("result without a pixel behind it");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("ready dropped without an accepted request");

endmodule

bind valid_2d_convolution vconv_checker u_vconv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/valid_2d_convolution_test.sv =====
// Self-checking bench for valid_2d_convolution: coefficient loads and raster frames
// over the stream ports, results compared against an in-bench correlation predictor.
// Depends on vconv_pkg and the valid_2d_convolution RTL.
`timescale 1ns / 100ps

module valid_2d_convolution_test;
    import vconv_pkg::*;

    localparam int KMAX = 15;
    localparam int WMAX = 2048;
    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [47:0] value;
        logic [10:0] row;
        logic [10:0] col;
        logic        last;
    } conv_result_t;

    typedef struct {
        logic        kind;
        logic [3:0]  crow;
        logic [3:0]  ccol;
        logic [15:0] cval;
        logic [15:0] pix;
        logic        known;
        logic [47:0] value;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DOUT_W-1:0] m_tdata;
    logic              m_tlast;

    valid_2d_convolution i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state
    int unsigned  img_w_reg, img_h_reg, ker_h_reg, ker_w_reg;
    logic [15:0]  line_mem [KMAX][WMAX];
    logic [15:0]  win [KMAX][KMAX];
    logic signed [15:0] coef [KMAX][KMAX];
    int unsigned  row_cnt, col_cnt;

    conv_result_t expected_q[$];
    logic         known_q[$];
    logic [47:0]  known_val_q[$];
    int           mismatches;
    longint       cycles;
    int           hold_off;
    int           send_gap_max;
    int           sent_items;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the correlation model by one request; returns 1 when a result is due
    function automatic bit convolve_step(logic kind, logic [3:0] crow, logic [3:0] ccol,
                                         logic [15:0] cval, logic [15:0] pix,
                                         output conv_result_t res);
        int unsigned w, h, kh, kw, r, c;
        logic [15:0] colv [KMAX];
        logic signed [63:0] acc;
        bit emit;
        w  = clamp_size(img_w_reg, WMAX);
        h  = clamp_size(img_h_reg, MAX_HEIGHT);
        kh = clamp_size(ker_h_reg, KMAX);
        kw = clamp_size(ker_w_reg, KMAX);
        r = row_cnt;
        c = col_cnt;
        emit = 0;
        res = '0;
        if (kind == ACT_COEF)
        begin
            if (crow < KMAX && ccol < KMAX)
                coef[crow][ccol] = cval;
            return 0;
        end
        if (c >= WMAX) c = 0;
        colv[0] = pix;
        for (int k = 1; k < KMAX; k++)
            colv[k] = line_mem[k-1][c];
        for (int k = KMAX - 1; k > 0; k--)
            line_mem[k-1][c] = colv[k-1];
        for (int k = 0; k < KMAX; k++)
        begin
            for (int j = KMAX - 1; j > 0; j--)
                win[k][j] = win[k][j-1];
            win[k][0] = colv[k];
        end
        if (r + 1 >= kh && c + 1 >= kw)
        begin
            acc = 0;
            for (int fh = 0; fh < kh; fh++)
                for (int fw = 0; fw < kw; fw++)
                    acc += $signed({48'd0, win[kh-1-fh][kw-1-fw]}) *
                           $signed({{48{coef[fh][fw][15]}}, coef[fh][fw]});
            res.value = acc[47:0];
            res.row   = 11'(r - (kh - 1));
            res.col   = 11'(c - (kw - 1));
            res.last  = (r + 1 >= h && c + 1 >= w);
            emit = 1;
        end
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
        return emit;
    endfunction

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   img_w_reg = value & 12'hFFF;
            REG_IMAGE_HEIGHT:  img_h_reg = value & 12'hFFF;
            REG_KERNEL_HEIGHT: ker_h_reg = value & 4'hF;
            default:           ker_w_reg = value & 4'hF;
        endcase
    endtask

    // drop the request line, then wait for every expected result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned kh, int unsigned kw);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_KERNEL_HEIGHT, kh);
        write_reg(REG_KERNEL_WIDTH, kw);
    endtask

    // offer one request and wait for it to be taken; called at a falling edge
    task automatic send_request(logic kind, logic [3:0] crow, logic [3:0] ccol,
                                logic [15:0] cval, logic [15:0] pix,
                                logic known, logic [47:0] kval);
        conv_result_t res;
        int gap;
        if (send_gap_max > 0 && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, send_gap_max);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pix, cval, ccol, crow};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_items++;
        if (convolve_step(kind, crow, ccol, cval, pix, res))
        begin
            expected_q.push_back(res);
            known_q.push_back(known);
            known_val_q.push_back(kval);
        end
        @(negedge clk);
    endtask

    task automatic load_kernel(int unsigned kh, int unsigned kw);
        for (int r = 0; r < kh; r++)
            for (int c = 0; c < kw; c++)
                send_request(ACT_COEF, 4'(r), 4'(c), 16'($urandom), 16'h0, 1'b0, '0);
    endtask

    // random coefficient noise plus a full frame of random pixels
    task automatic run_frame(int unsigned w, int unsigned h);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_request(ACT_COEF, 4'($urandom_range(15, 15)), 4'($urandom),
                             16'($urandom), 16'($urandom), 1'b0, '0);
            send_request(ACT_PIXEL, 4'($urandom), 4'($urandom), 16'($urandom),
                         ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
                         1'b0, '0);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int g;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        conv_result_t exp_r, got;
        logic known;
        logic [47:0] kval;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.value = m_tdata[47:0];
                got.row   = m_tdata[58:48];
                got.col   = m_tdata[69:59];
                got.last  = m_tlast;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    known = known_q.pop_front();
                    kval  = known_val_q.pop_front();
                    if (known && kval != exp_r.value)
                        exp_r.value = 'x;
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected val %h row %0d col %0d last %b, got val %h row %0d col %0d last %b",
                                     exp_r.value, exp_r.row, exp_r.col, exp_r.last,
                                     got.value, got.row, got.col, got.last);
                    end
                end
            end
        end
    end

    stim_row_t directed[$];

    task automatic add_row(logic kind, logic [3:0] crow, logic [3:0] ccol,
                           logic [15:0] cval, logic [15:0] pix,
                           logic known, logic [47:0] kval);
        stim_row_t s;
        s.kind = kind; s.crow = crow; s.ccol = ccol; s.cval = cval; s.pix = pix;
        s.known = known; s.value = kval;
        directed.push_back(s);
    endtask

    initial
    begin
        int n;
        int unsigned w, h, kh, kw;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_COEF;
        hold_off = 0;
        send_gap_max = 0;
        sent_items = 0;
        mismatches = 0;
        img_w_reg = 2048; img_h_reg = 2048; ker_h_reg = 15; ker_w_reg = 15;
        row_cnt = 0; col_cnt = 0;
        for (int a = 0; a < KMAX; a++)
        begin
            for (int b = 0; b < KMAX; b++)
            begin
                win[a][b] = '0;
                coef[a][b] = '0;
            end
            for (int b = 0; b < WMAX; b++)
                line_mem[a][b] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 1x1 kernel over a 2x2 frame, extremes with values read off by hand
        configure(2, 2, 1, 1);
        add_row(ACT_COEF, 4'd0, 4'd0, 16'h7FFF, 16'h0, 1'b0, '0);
        add_row(ACT_PIXEL, 4'd0, 4'd0, 16'h0, 16'hFFFF, 1'b1, 48'h7FFE_8001);
        add_row(ACT_COEF, 4'd0, 4'd0, 16'h8000, 16'hFFFF, 1'b0, '0);
        add_row(ACT_PIXEL, 4'd0, 4'd0, 16'h0, 16'hFFFF, 1'b1, 48'hFFFF_8000_8000);
        // out-of-range index is dropped
        add_row(ACT_COEF, 4'd15, 4'd0, 16'h1234, 16'h0, 1'b0, '0);
        add_row(ACT_COEF, 4'd0, 4'd15, 16'h1234, 16'h0, 1'b0, '0);
        add_row(ACT_PIXEL, 4'd0, 4'd0, 16'hFFFF, 16'h0000, 1'b1, 48'h0);
        add_row(ACT_PIXEL, 4'hF, 4'hF, 16'hFFFF, 16'h0001, 1'b1, 48'hFFFF_FFFF_8000);
        foreach (directed[i])
            send_request(directed[i].kind, directed[i].crow, directed[i].ccol,
                         directed[i].cval, directed[i].pix,
                         directed[i].known, directed[i].value);

        // zero sizes act as one; oversize kernel emits nothing
        configure(0, 0, 0, 0);
        send_request(ACT_COEF, 4'd0, 4'd0, 16'h4000, 16'h0, 1'b0, '0);
        send_request(ACT_PIXEL, 4'd0, 4'd0, 16'h0, 16'h8000, 1'b0, '0);
        configure(3, 3, 15, 15);
        load_kernel(15, 15);
        run_frame(3, 3);
        configure(4, 3, 3, 2);
        load_kernel(3, 2);
        run_frame(4, 3);

        // random phases: one full-size kernel frame under a long hold-off,
        // then many small frames and a few wider single rows
        send_gap_max = 3;
        n = 0;
        while (sent_items < 1450)
        begin
            if (n == 0)
            begin
                w = 16; h = 16; kh = 15; kw = 15;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                w = $urandom_range(17, 64); h = 1; kh = 1; kw = $urandom_range(1, 15);
            end
            else
            begin
                w = $urandom_range(1, 8); h = $urandom_range(1, 8);
                kh = $urandom_range(0, 15); kw = $urandom_range(0, 15);
                if ($urandom_range(0, 2) != 0)
                begin
                    kh = $urandom_range(1, h);
                    kw = $urandom_range(1, w);
                end
            end
            configure(w, h, kh, kw);
            load_kernel(clamp_size(kh, KMAX), clamp_size(kw, KMAX));
            // hold the receiver off long enough for the input to back up
            if (n == 0) hold_off = 2000;
            run_frame(clamp_size(w, WMAX), clamp_size(h, MAX_HEIGHT));
            n++;
        end

        drain_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
